// ----- design/morbit_pkg.sv -----
// shared types, constants and lookup functions for the morbit digit decoder
package morbit_pkg;

	localparam int COUNT_BITS = 14;
	localparam int KEY_BITS = 36;
	localparam int FILL_BITS = 5;
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 64;

	localparam logic [2:0] CODE_MAX_LEN = 3'd4;
	localparam logic [2:0] CODE_LEN_OVER = 3'd5;
	localparam logic [1:0] SEP_RUN_LIMIT = 2'd3;
	localparam logic [FILL_BITS-1:0] FILLER_RESET = 5'd23;
	localparam logic [31:0] ROM_VALID = 32'h3FD7_FFFC;

	// register index as seen on paddr[3]
	localparam logic REG_KEY_MAP = 1'b0;
	localparam logic REG_FILLER = 1'b1;

	localparam logic KIND_LETTER = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		SYM_DOT  = 2'd0,
		SYM_DASH = 2'd1,
		SYM_SEP  = 2'd2
	} sym_t;

	typedef struct packed {
		logic [2:0]            code_len;
		logic [4:0]            code_val;
		logic [1:0]            sep_run;
		logic [COUNT_BITS-1:0] tokens;
		logic [COUNT_BITS-1:0] letters;
	} mstate_t;

	localparam mstate_t ST_RESET = '{
		code_len: 3'd0,
		code_val: 5'd1,
		sep_run:  2'd0,
		tokens:   '0,
		letters:  '0
	};

	typedef struct packed {
		mstate_t              st;
		logic                 emit;
		logic [FILL_BITS-1:0] letter;
		logic                 ok;
	} step_t;

	typedef struct packed {
		logic                  kind;
		logic [4:0]            letter;
		logic                  letter_ok;
		logic [COUNT_BITS-1:0] token_count;
		logic [COUNT_BITS-1:0] valid_count;
		logic                  run_end;
	} res_t;

	function automatic logic [4:0] rom_letter(logic [4:0] code);
		logic [4:0] l;
		l = 5'd0;
		unique case (code)
			5'd2:  l = 5'd4;
			5'd3:  l = 5'd19;
			5'd4:  l = 5'd8;
			5'd6:  l = 5'd13;
			5'd7:  l = 5'd12;
			5'd8:  l = 5'd18;
			5'd9:  l = 5'd20;
			5'd10: l = 5'd17;
			5'd11: l = 5'd22;
			5'd12: l = 5'd3;
			5'd13: l = 5'd10;
			5'd14: l = 5'd6;
			5'd15: l = 5'd14;
			5'd16: l = 5'd7;
			5'd17: l = 5'd21;
			5'd18: l = 5'd5;
			5'd20: l = 5'd11;
			5'd22: l = 5'd15;
			5'd23: l = 5'd9;
			5'd24: l = 5'd1;
			5'd25: l = 5'd23;
			5'd26: l = 5'd2;
			5'd27: l = 5'd24;
			5'd28: l = 5'd25;
			5'd29: l = 5'd16;
			default: l = 5'd0;
		endcase
		return l;
	endfunction

	// pair / 3 as a symbol: values above two read as dot
	function automatic sym_t pair_top(logic [3:0] pair);
		sym_t s;
		s = SYM_DOT;
		case (pair) inside
			[4'd3:4'd5]: s = SYM_DASH;
			[4'd6:4'd8]: s = SYM_SEP;
			default:     s = SYM_DOT;
		endcase
		return s;
	endfunction

	// pair % 3 as a symbol
	function automatic sym_t pair_bot(logic [3:0] pair);
		sym_t s;
		s = SYM_DOT;
		case (pair) inside
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13: s = SYM_DASH;
			4'd2, 4'd5, 4'd8, 4'd11, 4'd14: s = SYM_SEP;
			default:                        s = SYM_DOT;
		endcase
		return s;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// one symbol against the codeword state
	function automatic step_t sym_step(mstate_t s, sym_t sym, logic [FILL_BITS-1:0] filler);
		step_t r;
		logic  ok;
		ok = 1'b0;
		r.st = s;
		r.emit = 1'b0;
		r.letter = filler;
		r.ok = 1'b0;
		if (sym == SYM_SEP) begin
			if (s.code_len != 3'd0) begin
				ok = (s.code_len <= CODE_MAX_LEN) && ROM_VALID[s.code_val];
				r.emit = 1'b1;
				r.ok = ok;
				if (ok) begin
					r.letter = rom_letter(s.code_val);
					r.st.letters = sat_inc(s.letters);
				end
				r.st.tokens = sat_inc(s.tokens);
				r.st.code_len = 3'd0;
				r.st.code_val = 5'd1;
			end
			if (s.sep_run < SEP_RUN_LIMIT) begin
				r.st.sep_run = s.sep_run + 2'd1;
			end
		end else begin
			// a long separator run just ended: one invalid token
			if (s.sep_run >= SEP_RUN_LIMIT) begin
				r.st.tokens = sat_inc(s.tokens);
			end
			r.st.sep_run = 2'd0;
			if (s.code_len < CODE_MAX_LEN) begin
				r.st.code_val = {s.code_val[3:0], sym == SYM_DASH};
			end
			if (s.code_len < CODE_LEN_OVER) begin
				r.st.code_len = s.code_len + 3'd1;
			end
		end
		return r;
	endfunction

endpackage

// ----- design/morbit_digit_to_morse_letter_decoder_core.sv -----
// morbit digit decoder: key lookup, morse codeword assembly and result queue
// an accepted digit waits in stage 1 until the result queue has room for its results
// throughput while res_ready is high: one digit per cycle if each digit yields at most
// one result; digits with two or three results drain one per cycle from the 4-entry queue
// reset: codeword state and counts cleared, key_map 0, filler_letter 23, queue empty
module morbit_digit_to_morse_letter_decoder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [morbit_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [morbit_pkg::DATA_BITS-1:0]     pwdata,
	output logic [morbit_pkg::DATA_BITS-1:0]     prdata,
	output logic                                 pready,
	// digit requests
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [3:0]                           digit,
	input  logic                                 last,
	// results
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic                                 kind,
	output logic [4:0]                           letter,
	output logic                                 letter_ok,
	output logic [morbit_pkg::COUNT_BITS-1:0]    token_count,
	output logic [morbit_pkg::COUNT_BITS-1:0]    valid_count,
	output logic                                 run_end
);

	logic [morbit_pkg::KEY_BITS-1:0]  key_map_q;
	logic [morbit_pkg::FILL_BITS-1:0] filler_q;
	logic                             cfg_wr;

	logic       valid_s1;
	logic [3:0] digit_s1;
	logic       last_s1;

	morbit_pkg::mstate_t st_q;
	morbit_pkg::mstate_t st_nxt;
	morbit_pkg::mstate_t st_dig;
	morbit_pkg::mstate_t st_end;

	morbit_pkg::res_t res_q [4];
	morbit_pkg::res_t res_nxt [4];
	logic [2:0]       cnt_q;
	logic [2:0]       cnt_nxt;
	logic [2:0]       base;
	logic [2:0]       pos;

	logic req_acc;
	logic pop;
	logic fire;

	logic             digit_ok;
	logic [3:0]       pair;
	morbit_pkg::step_t st_a;
	morbit_pkg::step_t st_b;
	morbit_pkg::step_t st_f;
	morbit_pkg::res_t cand [4];
	logic [3:0]       cand_en;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[3])
			morbit_pkg::REG_KEY_MAP:
				prdata = {{(morbit_pkg::DATA_BITS - morbit_pkg::KEY_BITS){1'b0}}, key_map_q};
			morbit_pkg::REG_FILLER:
				prdata = {{(morbit_pkg::DATA_BITS - morbit_pkg::FILL_BITS){1'b0}}, filler_q};
			default:
				prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q <= '0;
			filler_q <= morbit_pkg::FILLER_RESET;
		end else if (cfg_wr) begin
			if (paddr[3] == morbit_pkg::REG_KEY_MAP) begin
				key_map_q <= pwdata[morbit_pkg::KEY_BITS-1:0];
			end else begin
				filler_q <= pwdata[morbit_pkg::FILL_BITS-1:0];
			end
		end
	end

	// handshakes
	assign pop = res_valid & res_ready;
	assign base = cnt_q - {2'b00, pop};
	// room for three more results after this cycle's pop
	assign fire = valid_s1 && (base <= 3'd1);
	assign req_ready = !valid_s1 || fire;
	assign req_acc = req_valid & req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_acc | (valid_s1 & !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			digit_s1 <= digit;
			last_s1 <= last;
		end
	end

	// key lookup
	always_comb begin
		digit_ok = 1'b1;
		unique case (digit_s1)
			4'd1: pair = key_map_q[3:0];
			4'd2: pair = key_map_q[7:4];
			4'd3: pair = key_map_q[11:8];
			4'd4: pair = key_map_q[15:12];
			4'd5: pair = key_map_q[19:16];
			4'd6: pair = key_map_q[23:20];
			4'd7: pair = key_map_q[27:24];
			4'd8: pair = key_map_q[31:28];
			4'd9: pair = key_map_q[35:32];
			default: begin
				pair = 4'd0;
				digit_ok = 1'b0;
			end
		endcase
	end

	// top symbol, bottom symbol, then the end-of-message flush
	always_comb begin
		st_a = morbit_pkg::sym_step(st_q, morbit_pkg::pair_top(pair), filler_q);
		st_b = morbit_pkg::sym_step(st_a.st, morbit_pkg::pair_bot(pair), filler_q);
		st_dig = digit_ok ? st_b.st : st_q;
		st_f = morbit_pkg::sym_step(st_dig, morbit_pkg::SYM_SEP, filler_q);
		st_end = st_dig;
		if (st_dig.code_len != 3'd0) begin
			st_end = st_f.st;
		end else if (st_dig.sep_run >= morbit_pkg::SEP_RUN_LIMIT) begin
			// trailing separator run counts as one invalid token
			st_end.tokens = morbit_pkg::sat_inc(st_dig.tokens);
		end
		st_nxt = last_s1 ? morbit_pkg::ST_RESET : st_dig;

		cand_en[0] = digit_ok & st_a.emit;
		cand_en[1] = digit_ok & st_b.emit;
		cand_en[2] = last_s1 & (st_dig.code_len != 3'd0);
		cand_en[3] = last_s1;

		cand[0] = '{kind: morbit_pkg::KIND_LETTER, letter: st_a.letter, letter_ok: st_a.ok,
			token_count: '0, valid_count: '0, run_end: 1'b0};
		cand[1] = '{kind: morbit_pkg::KIND_LETTER, letter: st_b.letter, letter_ok: st_b.ok,
			token_count: '0, valid_count: '0, run_end: 1'b0};
		cand[2] = '{kind: morbit_pkg::KIND_LETTER, letter: st_f.letter, letter_ok: st_f.ok,
			token_count: '0, valid_count: '0, run_end: 1'b0};
		cand[3] = '{kind: morbit_pkg::KIND_SUMMARY, letter: 5'd0, letter_ok: 1'b0,
			token_count: st_end.tokens, valid_count: st_end.letters, run_end: 1'b0};

		// final result of the request carries run_end
		cand[0].run_end = cand_en[0] & ~|cand_en[3:1];
		cand[1].run_end = cand_en[1] & ~|cand_en[3:2];
		cand[2].run_end = cand_en[2] & ~cand_en[3];
		cand[3].run_end = cand_en[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= morbit_pkg::ST_RESET;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// result queue: head at entry 0, shifts on pop, new results packed after the tail
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_nxt[i] = pop ? res_q[i+1] : res_q[i];
		end
		res_nxt[3] = res_q[3];
		pos = base;
		if (fire) begin
			for (int j = 0; j < 4; j++) begin
				if (cand_en[j]) begin
					res_nxt[pos[1:0]] = cand[j];
					pos = pos + 3'd1;
				end
			end
		end
		cnt_nxt = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			res_q[i] <= res_nxt[i];
		end
	end

	assign res_valid = (cnt_q != 3'd0);
	assign kind = res_q[0].kind;
	assign letter = res_q[0].letter;
	assign letter_ok = res_q[0].letter_ok;
	assign token_count = res_q[0].token_count;
	assign valid_count = res_q[0].valid_count;
	assign run_end = res_q[0].run_end;

endmodule

// ----- tb/morbit_digit_to_morse_letter_decoder_core_tb.sv -----
// self-checking testbench for the morbit digit decoder: predicted letters and summaries
module morbit_digit_to_morse_letter_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_WIDTH = 36;
	localparam int WORD_MAX_SYMBOLS = 4;
	localparam int WORD_LEN_OVER = 5;
	localparam int LONG_SEP_RUN = 3;
	localparam int COUNT_MAX = (1 << morbit_pkg::COUNT_BITS) - 1;
	localparam logic [4:0] FILLER_AT_RESET = 5'd23;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES = 600000;
	localparam int LONG_DIGITS = 20;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_DIGITS = 28;

	// code value (leading one marker) -> letter, and which codes are real letters
	localparam logic [4:0] MORSE_LETTER [32] = '{
		5'd0, 5'd0, 5'd4, 5'd19, 5'd8, 5'd0, 5'd13, 5'd12,
		5'd18, 5'd20, 5'd17, 5'd22, 5'd3, 5'd10, 5'd6, 5'd14,
		5'd7, 5'd21, 5'd5, 5'd0, 5'd11, 5'd0, 5'd15, 5'd9,
		5'd1, 5'd23, 5'd2, 5'd24, 5'd25, 5'd16, 5'd0, 5'd0
	};
	localparam logic [31:0] MORSE_VALID = 32'h3FD7_FFFC;

	class letter_scoreboard;
		logic [KEY_WIDTH-1:0] key_map;
		logic [4:0]           filler;
		int unsigned          code_len;
		logic [4:0]           code_val;
		int unsigned          sep_run;
		int unsigned          tokens;
		int unsigned          letters;
		morbit_pkg::res_t     expected_results[$];
		morbit_pkg::res_t     step_results[$];
		int unsigned          mismatches;
		int unsigned          digits_noted;
		int unsigned          results_checked;
		int unsigned          messages_closed;

		function new();
			key_map = '0;
			filler = FILLER_AT_RESET;
			mismatches = 0;
			digits_noted = 0;
			results_checked = 0;
			messages_closed = 0;
			clear_message();
		endfunction

		function void clear_message();
			code_len = 0;
			code_val = 5'd1;
			sep_run = 0;
			tokens = 0;
			letters = 0;
		endfunction

		function int unsigned bump(int unsigned c);
			return (c < COUNT_MAX) ? c + 1 : c;
		endfunction

		// top or bottom third of a pair: two is a separator, one a dash, anything else a dot
		function morbit_pkg::sym_t to_sym(int unsigned v);
			if (v == 2)
				return morbit_pkg::SYM_SEP;
			else if (v == 1)
				return morbit_pkg::SYM_DASH;
			return morbit_pkg::SYM_DOT;
		endfunction

		function void push_result(logic k, logic [4:0] l, logic ok, int unsigned tok,
				int unsigned val);
			morbit_pkg::res_t r;
			r = '0;
			r.kind = k;
			r.letter = l;
			r.letter_ok = ok;
			r.token_count = tok[morbit_pkg::COUNT_BITS-1:0];
			r.valid_count = val[morbit_pkg::COUNT_BITS-1:0];
			step_results.push_back(r);
		endfunction

		function void decode_symbol(morbit_pkg::sym_t s);
			if (s == morbit_pkg::SYM_SEP) begin
				if (code_len > 0) begin
					if (code_len <= WORD_MAX_SYMBOLS && MORSE_VALID[code_val]) begin
						push_result(morbit_pkg::KIND_LETTER, MORSE_LETTER[code_val], 1'b1,
							0, 0);
						letters = bump(letters);
					end else begin
						push_result(morbit_pkg::KIND_LETTER, filler, 1'b0, 0, 0);
					end
					tokens = bump(tokens);
					code_len = 0;
					code_val = 5'd1;
				end
				if (sep_run < LONG_SEP_RUN)
					sep_run++;
			end else begin
				// a long separator run ends as one invalid token
				if (sep_run >= LONG_SEP_RUN)
					tokens = bump(tokens);
				sep_run = 0;
				if (code_len < WORD_MAX_SYMBOLS)
					code_val = {code_val[3:0], s == morbit_pkg::SYM_DASH};
				if (code_len < WORD_LEN_OVER)
					code_len++;
			end
		endfunction

		function void note_digit(logic [3:0] dgt, logic lst);
			int          d;
			int unsigned pair;
			d = dgt;
			step_results.delete();
			digits_noted++;
			if (d >= 1 && d <= 9) begin
				pair = key_map[4*(d-1) +: 4];
				decode_symbol(to_sym(pair / 3));
				decode_symbol(to_sym(pair % 3));
			end
			if (lst) begin
				if (code_len > 0)
					decode_symbol(morbit_pkg::SYM_SEP);
				else if (sep_run >= LONG_SEP_RUN)
					tokens = bump(tokens);
				push_result(morbit_pkg::KIND_SUMMARY, 5'd0, 1'b0, tokens, letters);
				clear_message();
				messages_closed++;
			end
			if (step_results.size() > 0)
				step_results[step_results.size()-1].run_end = 1'b1;
			foreach (step_results[i])
				expected_results.push_back(step_results[i]);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(morbit_pkg::res_t got);
			morbit_pkg::res_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d letter %0d",
					$time, got.kind, got.letter);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("letter", 32'(want.letter), 32'(got.letter));
			compare_field("letter_ok", 32'(want.letter_ok), 32'(got.letter_ok));
			compare_field("token_count", 32'(want.token_count), 32'(got.token_count));
			compare_field("valid_count", 32'(want.valid_count), 32'(got.valid_count));
			compare_field("run_end", 32'(want.run_end), 32'(got.run_end));
		endfunction
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 psel = 1'b0;
	logic                                 penable = 1'b0;
	logic                                 pwrite = 1'b0;
	logic [morbit_pkg::ADDR_BITS-1:0]     paddr = '0;
	logic [morbit_pkg::DATA_BITS-1:0]     pwdata = '0;
	logic [morbit_pkg::DATA_BITS-1:0]     prdata;
	logic                                 pready;
	logic                                 req_valid = 1'b0;
	logic                                 req_ready;
	logic [3:0]                           digit = 4'd0;
	logic                                 last = 1'b0;
	logic                                 res_valid;
	logic                                 res_ready = 1'b0;
	logic                                 kind;
	logic [4:0]                           letter;
	logic                                 letter_ok;
	logic [morbit_pkg::COUNT_BITS-1:0]    token_count;
	logic [morbit_pkg::COUNT_BITS-1:0]    valid_count;
	logic                                 run_end;

	letter_scoreboard sb;
	bit               steady = 1'b0;
	bit               hold_asked = 1'b0;
	bit               hold_done = 1'b0;
	int               hold_left = 0;
	int unsigned      cycles = 0;
	int unsigned      reg_writes = 0;

	morbit_digit_to_morse_letter_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.digit       (digit),
		.last        (last),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.kind        (kind),
		.letter      (letter),
		.letter_ok   (letter_ok),
		.token_count (token_count),
		.valid_count (valid_count),
		.run_end     (run_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				sb.expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: check, then decide ready for the next edge
	always @(posedge clk) begin
		if (res_valid && res_ready)
			sb.check_result({kind, letter, letter_ok, token_count, valid_count, run_end});
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (hold_asked && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_ready <= 1'b0;
		end else begin
			res_ready <= arst_n && (steady || $urandom_range(0, 99) >= 20);
		end
	end

	task automatic send_digit(input logic [3:0] dgt, input logic lst);
		req_valid <= 1'b1;
		digit <= dgt;
		last <= lst;
		do @(posedge clk); while (!req_ready);
		sb.note_digit(dgt, lst);
		if (!steady && $urandom_range(0, 99) < 20) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 20);
		end
	endtask

	// let every outstanding result arrive and the pipeline empty out
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic sel,
			input logic [morbit_pkg::DATA_BITS-1:0] value);
		logic [morbit_pkg::DATA_BITS-1:0] want;
		logic [morbit_pkg::DATA_BITS-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read back what was just written
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		want = '0;
		if (sel == morbit_pkg::REG_KEY_MAP) begin
			sb.key_map = value[KEY_WIDTH-1:0];
			want[KEY_WIDTH-1:0] = value[KEY_WIDTH-1:0];
		end else begin
			sb.filler = value[4:0];
			want[4:0] = value[4:0];
		end
		reg_writes++;
		if (got !== want) begin
			$display("%0t: register %0d readback, expected %0h, actual %0h", $time, sel,
				want, got);
			sb.mismatches++;
		end
	endtask

	function automatic logic [3:0] pick_digit();
		if ($urandom_range(0, 99) < 12)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(1, 9));
	endfunction

	function automatic logic [morbit_pkg::DATA_BITS-1:0] random_key();
		logic [morbit_pkg::DATA_BITS-1:0] k;
		k = '0;
		for (int i = 0; i < 9; i++) begin
			if ($urandom_range(0, 7) == 0)
				k[4*i +: 4] = 4'($urandom_range(0, 15));
			else
				k[4*i +: 4] = 4'($urandom_range(0, 8));
		end
		return k;
	endfunction

	initial begin
		int sent;
		int len;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every digit is two dots, six dots overflow the codeword
		send_digit(4'd1, 1'b0);
		send_digit(4'd1, 1'b0);
		send_digit(4'd1, 1'b1);
		send_digit(4'd0, 1'b0);
		send_digit(4'd15, 1'b1);
		settle();

		// digit d maps to pair d-1, so every symbol combination shows up
		write_register(morbit_pkg::REG_KEY_MAP, 64'h8_7654_3210);
		write_register(morbit_pkg::REG_FILLER, 64'd0);
		send_digit(4'd3, 1'b0);
		send_digit(4'd5, 1'b0);
		send_digit(4'd6, 1'b0);
		// long separator run, then a codeword past four symbols
		send_digit(4'd9, 1'b0);
		send_digit(4'd9, 1'b0);
		send_digit(4'd1, 1'b0);
		send_digit(4'd2, 1'b0);
		send_digit(4'd2, 1'b0);
		send_digit(4'd9, 1'b0);
		send_digit(4'd4, 1'b0);
		send_digit(4'd6, 1'b0);
		// separator closes a word, a dot opens one, last flushes it: three results
		send_digit(4'd1, 1'b0);
		send_digit(4'd7, 1'b1);
		// trailing separator run with out-of-range digits mixed in
		send_digit(4'd8, 1'b0);
		send_digit(4'd9, 1'b0);
		send_digit(4'd0, 1'b0);
		send_digit(4'd12, 1'b0);
		send_digit(4'd9, 1'b1);
		send_digit(4'd13, 1'b1);
		settle();

		// pair indices 9..15
		write_register(morbit_pkg::REG_KEY_MAP, 64'h1_0FED_CBA9);
		write_register(morbit_pkg::REG_FILLER, 64'd31);
		for (int d = 1; d <= 8; d++)
			send_digit(4'(d), 1'b0);
		send_digit(4'd9, 1'b1);
		settle();
		write_register(morbit_pkg::REG_KEY_MAP, 64'hF_FFFF_FFFF);
		send_digit(4'd4, 1'b0);
		send_digit(4'd10, 1'b1);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			write_register(morbit_pkg::REG_KEY_MAP, random_key());
			write_register(morbit_pkg::REG_FILLER, 64'($urandom_range(0, 31)));
			steady = (phase == 1);
			if (phase == 3)
				hold_asked = 1'b1;
			sent = 0;
			while (sent < PHASE_DIGITS) begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					send_digit(pick_digit(), i == len - 1 || $urandom_range(0, 99) < 4);
				sent += len;
			end
		end
		steady = 1'b0;

		// one long message of single-dot letters
		settle();
		write_register(morbit_pkg::REG_KEY_MAP, 64'h2);
		write_register(morbit_pkg::REG_FILLER, 64'($urandom_range(0, 31)));
		repeat (LONG_DIGITS) send_digit(4'd1, 1'b0);
		send_digit(4'd1, 1'b1);
		settle();

		$display("covered %0d digit requests in %0d messages, %0d results checked",
			sb.digits_noted, sb.messages_closed, sb.results_checked);
		$display("%0d register writes incl. extreme keys and fillers, plus a long held-off stall",
			reg_writes);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- morbit_digit_to_morse_letter_decoder_core.f -----
design/morbit_pkg.sv
design/morbit_digit_to_morse_letter_decoder_core.sv
tb/morbit_digit_to_morse_letter_decoder_core_tb.sv
